// File: rtl/core/atp_pkg.sv
// Shared constants, types and the arctangent table for the tilt angle block.
`default_nettype none
package atp_pkg;

    localparam int SAMPLE_BITS  = 10;
    localparam int CORDIC_STEPS = 20;
    localparam int FRAC_XY      = 12;
    localparam int FRAC_ANG     = 16;
    localparam int MAP_W        = 11;
    localparam int NUM_W        = SAMPLE_BITS + 8;
    localparam int DEG_W        = 9;
    localparam int XY_W         = MAP_W + FRAC_XY + 2;
    localparam int Z_W          = 25;
    localparam int NUM_REGS     = 6;
    localparam int ADDR_W       = 5;

    localparam logic [2:0] REG_X_LO = 3'd0;
    localparam logic [2:0] REG_X_HI = 3'd1;
    localparam logic [2:0] REG_Y_LO = 3'd2;
    localparam logic [2:0] REG_Y_HI = 3'd3;
    localparam logic [2:0] REG_Z_LO = 3'd4;
    localparam logic [2:0] REG_Z_HI = 3'd5;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
    } t_cal;

    typedef enum logic [1:0] {
        DM_ZERO,
        DM_EQ,
        DM_LT,
        DM_GT
    } t_dir_mode;

    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(2949120);
            1:  v = Z_W'(1740967);
            2:  v = Z_W'(919879);
            3:  v = Z_W'(466945);
            4:  v = Z_W'(234379);
            5:  v = Z_W'(117304);
            6:  v = Z_W'(58666);
            7:  v = Z_W'(29335);
            8:  v = Z_W'(14668);
            9:  v = Z_W'(7334);
            10: v = Z_W'(3667);
            11: v = Z_W'(1833);
            12: v = Z_W'(917);
            13: v = Z_W'(458);
            14: v = Z_W'(229);
            15: v = Z_W'(115);
            16: v = Z_W'(57);
            17: v = Z_W'(29);
            18: v = Z_W'(14);
            19: v = Z_W'(7);
            20: v = Z_W'(4);
            21: v = Z_W'(2);
            22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/atp_map.sv
// One axis lane: calibrated linear map with a pipelined restoring divider.
`default_nettype none
module atp_map
    import atp_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire  [SAMPLE_BITS-1:0]     i_sample,
    input  t_cal                       i_cal,
    output logic                       o_valid,
    output logic signed [MAP_W-1:0]    o_value
);

    localparam logic signed [NUM_W:0]   MUL_K  = (NUM_W+1)'(200);
    localparam logic signed [NUM_W+1:0] OFS    = (NUM_W+2)'(100);
    localparam logic signed [NUM_W+1:0] SAT_LO = -(NUM_W+2)'(2**(MAP_W-1));
    localparam logic signed [NUM_W+1:0] SAT_HI = (NUM_W+2)'(2**(MAP_W-1) - 1);

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [NUM_W:0]       prod;
    logic                        empty;

    logic [NUM_W-1:0]       r_num   [NUM_W+1];
    logic [SAMPLE_BITS-1:0] r_rem   [NUM_W+1];
    logic [SAMPLE_BITS-1:0] r_d     [NUM_W+1];
    logic                   r_neg   [NUM_W+1];
    logic                   r_empty [NUM_W+1];
    logic                   r_v     [NUM_W+1];

    assign diff  = $signed({1'b0, i_sample}) - $signed({1'b0, i_cal.lo});
    assign prod  = (NUM_W+1)'(diff) * MUL_K;
    assign empty = i_cal.lo >= i_cal.hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_neg[0]   <= prod[NUM_W];
            r_num[0]   <= prod[NUM_W] ? NUM_W'(-prod) : prod[NUM_W-1:0];
            r_rem[0]   <= '0;
            r_empty[0] <= empty;
            r_d[0]     <= empty ? SAMPLE_BITS'(1) : i_cal.hi - i_cal.lo;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        logic [SAMPLE_BITS:0] tmp;
        logic                 ge;
        assign tmp = {r_rem[k], r_num[k][NUM_W-1]};
        assign ge  = tmp >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]   <= ge ? SAMPLE_BITS'(tmp - {1'b0, r_d[k]})
                                   : tmp[SAMPLE_BITS-1:0];
                r_num[k+1]   <= {r_num[k][NUM_W-2:0], ge};
                r_d[k+1]     <= r_d[k];
                r_neg[k+1]   <= r_neg[k];
                r_empty[k+1] <= r_empty[k];
            end
        end
    end

    logic signed [NUM_W+1:0] sq;
    logic signed [NUM_W+1:0] m;
    logic signed [MAP_W-1:0] n_value;

    always_comb begin
        sq = $signed({2'b00, r_num[NUM_W]});
        if (r_neg[NUM_W]) begin
            sq = -sq;
        end
        m = sq - OFS;
        if (r_empty[NUM_W]) begin
            n_value = '0;
        end else if (m < SAT_LO) begin
            n_value = SAT_LO[MAP_W-1:0];
        end else if (m > SAT_HI) begin
            n_value = SAT_HI[MAP_W-1:0];
        end else begin
            n_value = m[MAP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[NUM_W];
        end
        if (i_en) begin
            o_value <= n_value;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/atp_dir.sv
// One angle lane: quadrant fold, pipelined vectoring CORDIC, degree assembly.
`default_nettype none
module atp_dir
    import atp_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire                        i_valid,
    input  wire  signed [MAP_W-1:0]    i_a,
    input  wire  signed [MAP_W-1:0]    i_b,
    output logic                       o_valid,
    output logic [DEG_W-1:0]           o_deg
);

    logic [MAP_W-1:0]  neg_a, neg_b, p, q;
    logic [DEG_W-1:0]  base;
    t_dir_mode         mode;

    assign neg_a = MAP_W'(-(MAP_W+1)'(i_a));
    assign neg_b = MAP_W'(-(MAP_W+1)'(i_b));

    always_comb begin
        if (i_a > 0 && i_b >= 0) begin
            p = i_a; q = i_b; base = DEG_W'(0);
        end else if (i_a <= 0 && i_b > 0) begin
            p = i_b; q = neg_a; base = DEG_W'(90);
        end else if (i_a < 0 && i_b <= 0) begin
            p = neg_a; q = neg_b; base = DEG_W'(180);
        end else begin
            p = neg_b; q = i_a; base = DEG_W'(270);
        end
        if ((i_a == 0 && i_b == 0) || q == 0) begin
            mode = DM_ZERO;
        end else if (q == p) begin
            mode = DM_EQ;
        end else if (q < p) begin
            mode = DM_LT;
        end else begin
            mode = DM_GT;
        end
        if (i_a == 0 && i_b == 0) begin
            base = '0;
        end
    end

    logic signed [XY_W-1:0] r_x    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] r_y    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  r_z    [CORDIC_STEPS+1];
    t_dir_mode              r_mode [CORDIC_STEPS+1];
    logic [DEG_W-1:0]       r_base [CORDIC_STEPS+1];
    logic                   r_v    [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_x[0]    <= $signed({(XY_W-MAP_W-FRAC_XY)'(0), (mode == DM_GT) ? q : p,
                                  FRAC_XY'(0)});
            r_y[0]    <= $signed({(XY_W-MAP_W-FRAC_XY)'(0), (mode == DM_GT) ? p : q,
                                  FRAC_XY'(0)});
            r_z[0]    <= '0;
            r_mode[0] <= mode;
            r_base[0] <= base;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [XY_W-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (i_en) begin
                if (!r_y[i][XY_W-1]) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + atan_deg(i);
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - atan_deg(i);
                end
                r_mode[i+1] <= r_mode[i];
                r_base[i+1] <= r_base[i];
            end
        end
    end

    logic signed [Z_W-1:0] zs;
    logic [5:0]            f;
    logic [DEG_W-1:0]      t;
    logic [DEG_W-1:0]      sum;
    logic [DEG_W-1:0]      n_deg;

    always_comb begin
        zs = r_z[CORDIC_STEPS] >>> FRAC_ANG;
        if (r_z[CORDIC_STEPS] < 0) begin
            f = '0;
        end else if (zs > 44) begin
            f = 6'd44;
        end else begin
            f = zs[5:0];
        end
        case (r_mode[CORDIC_STEPS])
            DM_ZERO: t = '0;
            DM_EQ:   t = DEG_W'(45);
            DM_LT:   t = DEG_W'(f);
            default: t = DEG_W'(89) - DEG_W'(f);
        endcase
        sum   = r_base[CORDIC_STEPS] + t;
        n_deg = (sum > DEG_W'(359)) ? DEG_W'(359) : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[CORDIC_STEPS];
        end
        if (i_en) begin
            o_deg <= n_deg;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/accelerometer_tilt_angles.sv
// Top level: calibration registers, three axis lanes, two angle lanes, output register.
//
// Slave stream carries one beat of raw X, Y, Z samples; the master stream returns
// one beat with pitch (Z against X) and roll (X against Y), in whole degrees 0..359.
// Calibration low/high pairs sit on the APB port at byte addresses 0x00..0x14;
// write them only while no beat is in flight.
// One beat is taken every cycle while o_s_tready is high. The axis lanes run one
// divider stage per quotient bit, the angle lanes one CORDIC iteration per stage
// over 20 CORDIC steps, and the output register follows the angle lanes.
// The whole pipeline advances together; while the receiver holds tready low with
// a beat waiting in the output register, every stage holds and o_s_tready is low.
// Reset empties the pipeline and loads the default calibration.
`default_nettype none
module accelerometer_tilt_angles
    import atp_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  wire  [31:0]         i_s_tdata,  // x_sample, y_sample, z_sample, zero pad
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [23:0]         o_m_tdata,  // pitch_deg, roll_deg, zero pad
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [SAMPLE_BITS-1:0] r_cal [NUM_REGS];
    logic [2:0]             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal[REG_X_LO] <= SAMPLE_BITS'(268);
            r_cal[REG_X_HI] <= SAMPLE_BITS'(407);
            r_cal[REG_Y_LO] <= SAMPLE_BITS'(260);
            r_cal[REG_Y_HI] <= SAMPLE_BITS'(401);
            r_cal[REG_Z_LO] <= SAMPLE_BITS'(270);
            r_cal[REG_Z_HI] <= SAMPLE_BITS'(406);
        end else if (psel && penable && pwrite && pready && reg_idx < 3'(NUM_REGS)) begin
            r_cal[reg_idx] <= pwdata[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < 3'(NUM_REGS)) begin
            prdata = 32'(r_cal[reg_idx]);
        end
    end

    logic en;
    assign en         = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    logic                    map_v [3];
    logic signed [MAP_W-1:0] map_m [3];

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        t_cal cal;
        assign cal.lo = r_cal[2*ax];
        assign cal.hi = r_cal[2*ax+1];
        atp_map u_map (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (i_s_tvalid),
            .i_sample (i_s_tdata[ax*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_cal    (cal),
            .o_valid  (map_v[ax]),
            .o_value  (map_m[ax])
        );
    end

    logic             pitch_v, roll_v;
    logic [DEG_W-1:0] pitch, roll;

    atp_dir u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (map_v[0]),
        .i_a     (map_m[0]),
        .i_b     (map_m[2]),
        .o_valid (pitch_v),
        .o_deg   (pitch)
    );

    atp_dir u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (map_v[0]),
        .i_a     (map_m[1]),
        .i_b     (map_m[0]),
        .o_valid (roll_v),
        .o_deg   (roll)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (en) begin
            o_m_tvalid <= pitch_v;
        end
        if (en) begin
            o_m_tdata <= {6'd0, roll, pitch};
        end
    end

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output register");
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pitch_v == roll_v && map_v[0] == map_v[1] && map_v[1] == map_v[2])
        else $error("lanes out of step");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[8:0] < 9'd360 && o_m_tdata[17:9] < 9'd360))
        else $error("angle out of range");

endmodule
`default_nettype wire
